>>> src/assert_macros.svh
// assertion macros for the per-pixel frame delay block
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define PFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked at every rising edge, reset included
`define PFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/pfd_pkg.sv
// shared types and constants for the per-pixel frame delay block
// no dependencies
package pfd_pkg;

  localparam int unsigned X_W      = 12;
  localparam int unsigned Y_W      = 12;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned DELAY_W  = 4;
  localparam int unsigned MAP_W    = 13;
  localparam int unsigned PROD_W   = Y_W + MAP_W;
  localparam int unsigned MIDX_W   = PROD_W + 1;
  localparam int unsigned NUM_DLY  = 2 ** DELAY_W;
  localparam int unsigned FCOUNT_W = 32;

  localparam int unsigned MAP_PIXELS_DEF = 4096;
  localparam int unsigned MAX_DELAY_DEF  = 16;

  typedef enum logic {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [RGB_W-1:0]   pixel_rgb;
    logic [DELAY_W-1:0] delay_frames;
    logic               frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [RGB_W-1:0] delayed_rgb;
    logic             frame_done;
  } pix_out_t;

endpackage

>>> src/pfd_slot_gen.sv
// frame counter with one running residue per possible delay value
// depends on pfd_pkg
module pfd_slot_gen import pfd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [DELAY_W-1:0] delay_i,
  output logic [DELAY_W-1:0] slot_o
);

  logic [FCOUNT_W-1:0] fcount_q, fcount_d;
  logic [DELAY_W-1:0]  res_q [NUM_DLY];
  logic [DELAY_W-1:0]  res_d [NUM_DLY];

  // residue d holds frame_count mod d; entry zero is never used
  always_comb begin
    fcount_d = fcount_q + FCOUNT_W'(1);
    res_d[0] = '0;
    for (int d = 1; d < NUM_DLY; d++) begin
      if (fcount_q == '1) begin
        res_d[d] = '0;  // count wraps to zero, so do all residues
      end else if (res_q[d] == DELAY_W'(d - 1)) begin
        res_d[d] = '0;
      end else begin
        res_d[d] = res_q[d] + DELAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q <= '0;
      for (int d = 0; d < NUM_DLY; d++) begin
        res_q[d] <= '0;
      end
    end else if (adv_i) begin
      fcount_q <= fcount_d;
      for (int d = 0; d < NUM_DLY; d++) begin
        res_q[d] <= res_d[d];
      end
    end
  end

  assign slot_o = res_q[delay_i];

endmodule

>>> src/pfd_hist_mem.sv
// history memory: one write port, one registered read port, clearing sweep after reset
// depends on pfd_pkg
module pfd_hist_mem import pfd_pkg::*; #(
  parameter longint unsigned DEPTH  = 65536,
  parameter int unsigned     ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [RGB_W-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [RGB_W-1:0]  rd_data_o,
  output logic              busy_o
);

  logic [RGB_W-1:0]  mem_q [DEPTH];
  logic [RGB_W-1:0]  rd_data_q;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              busy_q, busy_d;

  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d     = busy_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q     <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      busy_q     <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

>>> src/per_pixel_frame_delay.sv
//  channel | direction | handshake                  | payload
//  in      | in        | in_valid_i / in_stall_o    | in_data_i  (pix_in_t)
//  out     | out       | out_valid_o / out_stall_i  | out_data_o (pix_out_t)
//  cfg     | in        | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
//  one item per clock sustained while out_stall_i is low; each item passes the stages
//  in order: range checks and y*width product, map index and capacity check, store address,
//  history read with write-to-read forwarding, output register
//  after reset the history store, MAP_PIXELS*MAX_DELAY entries (65536 by default), is
//  swept to zero, one entry per cycle; in_stall_o stays high meanwhile
//  a stall on out reaches back combinationally through the full stages; bubbles are squeezed out
//  depends on pfd_pkg, pfd_slot_gen, pfd_hist_mem and assert_macros.svh
`include "assert_macros.svh"

module per_pixel_frame_delay import pfd_pkg::*; #(
  parameter int unsigned MAP_PIXELS = MAP_PIXELS_DEF,
  parameter int unsigned MAX_DELAY  = MAX_DELAY_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pix_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pix_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [MAP_W-1:0] cfg_data_i
);

  localparam longint unsigned STORE_DEPTH = longint'(MAP_PIXELS) * longint'(MAX_DELAY);
  localparam int unsigned     ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned     IDX_W       = (MAP_PIXELS > 1) ? $clog2(MAP_PIXELS) : 1;

  // configuration
  logic [MAP_W-1:0] map_width_q, map_height_q;
  logic             enabled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= '0;
      map_height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i;
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign enabled = (map_width_q != '0) && (map_height_q != '0);

  // pipeline flow control: a stage loads when it is empty or its item moves on
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic r1, r2, r3, r4, r_out;
  logic in_acc, clr_busy;

  assign r_out  = !out_v_q || !out_stall_i;
  assign r4     = !v4_q || r_out;
  assign r3     = !v3_q || r4;
  assign r2     = !v2_q || r3;
  assign r1     = !v1_q || r2;

  assign in_stall_o = clr_busy || !r1;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (r1)    v1_q    <= in_acc;
      if (r2)    v2_q    <= v1_q;
      if (r3)    v3_q    <= v2_q;
      if (r4)    v4_q    <= v3_q;
      if (r_out) out_v_q <= v4_q;
    end
  end

  // per-delay slot; the frame count moves after the marked item takes its slot
  logic [DELAY_W-1:0] slot;

  pfd_slot_gen u_slot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (in_acc && enabled && in_data_i.frame_end),
    .delay_i (in_data_i.delay_frames),
    .slot_o  (slot)
  );

  // stage 1: range checks and the row product
  logic [X_W-1:0]     s1_x_q;
  logic [RGB_W-1:0]   s1_rgb_q;
  logic               s1_fend_q;
  logic [DELAY_W-1:0] s1_slot_q, s1_delay_q;
  logic               s1_ok_q, s1_ok_d;
  logic [PROD_W-1:0]  s1_prod_q;

  assign s1_ok_d = enabled
                && (in_data_i.delay_frames != '0)
                && (32'(in_data_i.delay_frames) <= MAX_DELAY)
                && ({1'b0, in_data_i.pixel_x} < map_width_q)
                && ({1'b0, in_data_i.pixel_y} < map_height_q);

  always_ff @(posedge clk_i) begin
    if (r1 && in_acc) begin
      s1_x_q     <= in_data_i.pixel_x;
      s1_rgb_q   <= in_data_i.pixel_rgb;
      s1_fend_q  <= in_data_i.frame_end;
      s1_slot_q  <= slot;
      s1_delay_q <= in_data_i.delay_frames;
      s1_ok_q    <= s1_ok_d;
      s1_prod_q  <= PROD_W'(in_data_i.pixel_y) * PROD_W'(map_width_q);
    end
  end

  // stage 2: map index and capacity check
  logic [MIDX_W-1:0]  map_idx;
  logic [IDX_W-1:0]   s2_idx_q;
  logic [RGB_W-1:0]   s2_rgb_q;
  logic               s2_fend_q, s2_acc_q;
  logic [DELAY_W-1:0] s2_slot_q;

  assign map_idx = MIDX_W'(s1_prod_q) + MIDX_W'(s1_x_q);

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      s2_idx_q  <= map_idx[IDX_W-1:0];
      s2_acc_q  <= s1_ok_q && (map_idx < MIDX_W'(MAP_PIXELS));
      s2_rgb_q  <= s1_rgb_q;
      s2_fend_q <= s1_fend_q;
      s2_slot_q <= s1_slot_q;
    end
  end

  // stage 3: entry address in the history store
  logic [ADDR_W-1:0] s3_addr_q;
  logic [RGB_W-1:0]  s3_rgb_q;
  logic              s3_fend_q, s3_acc_q;

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      s3_addr_q <= ADDR_W'(s2_idx_q) * ADDR_W'(MAX_DELAY) + ADDR_W'(s2_slot_q);
      s3_acc_q  <= s2_acc_q;
      s3_rgb_q  <= s2_rgb_q;
      s3_fend_q <= s2_fend_q;
    end
  end

  // stage 4: history read; the item leaving stage 4 writes the same edge,
  // so a read of that entry takes the new pixel instead
  logic [ADDR_W-1:0] s4_addr_q;
  logic [RGB_W-1:0]  s4_rgb_q, fwd_rgb_q, rd_data;
  logic              s4_fend_q, s4_acc_q, fwd_q;
  logic              ld4, wr_en;

  assign ld4   = r4 && v3_q;
  assign wr_en = v4_q && r_out && s4_acc_q;

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      s4_addr_q <= s3_addr_q;
      s4_acc_q  <= s3_acc_q;
      s4_rgb_q  <= s3_rgb_q;
      s4_fend_q <= s3_fend_q;
      fwd_q     <= wr_en && (s4_addr_q == s3_addr_q);
      fwd_rgb_q <= s4_rgb_q;
    end
  end

  pfd_hist_mem #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (s4_addr_q),
    .wr_data_i (s4_rgb_q),
    .rd_en_i   (ld4 && s3_acc_q),
    .rd_addr_i (s3_addr_q),
    .rd_data_o (rd_data),
    .busy_o    (clr_busy)
  );

  // output register
  pix_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (r_out && v4_q) begin
      if (!s4_acc_q) begin
        out_q.delayed_rgb <= s4_rgb_q;  // pass-through
      end else if (fwd_q) begin
        out_q.delayed_rgb <= fwd_rgb_q;
      end else begin
        out_q.delayed_rgb <= rd_data;
      end
      out_q.frame_done <= s4_fend_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // no item enters while the store is being cleared
  `PFD_ASSERT(a_no_accept_clear, clr_busy |-> !in_acc, "item accepted during clear sweep")
  // a slot always lies below its own delay
  `PFD_ASSERT(a_slot_range, (v1_q && s1_ok_q) |-> (s1_slot_q < s1_delay_q), "slot not below delay")
  // a blocked stage 4 keeps its item and address
  `PFD_ASSERT(a_s4_hold, (v4_q && !r4) |=> (v4_q && $stable(s4_addr_q)), "stage 4 lost item")
  // the store is never written before the clear sweep ends
  `PFD_ASSERT_ALWAYS(a_no_wr_clear, (rst_ni && clr_busy) |-> !wr_en, "write during clear sweep")

endmodule

>>> tb/sv/tb_per_pixel_frame_delay.sv
// self-checking testbench for per_pixel_frame_delay: random and directed pixel items
// are checked against a behavioral slit-scan history model; depends on pfd_pkg and per_pixel_frame_delay
module tb_per_pixel_frame_delay;
  import pfd_pkg::*;

  // run length and pacing
  localparam int unsigned STORE_DEPTH  = MAP_PIXELS_DEF * MAX_DELAY_DEF;
  localparam int unsigned CYCLE_LIMIT  = 400000;  // covers the post-reset store sweep too
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 10;      // comfortably past the depth of the five-stage pipeline

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  // block ports, all known from time zero
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  pix_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  pix_out_t         out_data_o;
  logic             cfg_we_i    = 1'b0;
  cfg_reg_e         cfg_idx_i   = CFG_MAP_WIDTH;
  logic [MAP_W-1:0] cfg_data_i  = '0;

  per_pixel_frame_delay DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // model state: per-position history rings, frame count and map size
  logic [RGB_W-1:0]    pixel_history [STORE_DEPTH];
  logic [FCOUNT_W-1:0] frame_count_q = '0;
  logic [MAP_W-1:0]    map_width_q   = '0;
  logic [MAP_W-1:0]    map_height_q  = '0;

  // items waiting for the driver and results waiting for the block
  pix_in_t  pending_pixels [$];
  pix_out_t due_pixels [$];
  pix_out_t pixel_want;

  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // pacing state shared between the stimulus and the two channel processes
  bit          tx_idle_on    = 1'b1;
  bit          rx_idle_on    = 1'b1;
  bit          in_taken      = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned tx_wait       = 0;
  int unsigned rx_wait       = 0;
  int unsigned rx_hold       = 0;

  // delay per map position for well-formed frames
  logic [DELAY_W-1:0] slit_delay [64];

  // with idling on, half the items go back to back and the rest wait a random gap; with it off all go back to back
  function automatic int unsigned draw_wait(bit idle_on);
    if (idle_on && $urandom_range(0, 1))
      return $urandom_range(0, 16);
    return 0;
  endfunction

  // pixel seen at this position delay frames ago; updates the history and frame count
  function automatic pix_out_t delayed_pixel(pix_in_t px);
    pix_out_t    res;
    logic        map_on;
    int unsigned map_index;
    int unsigned slot;
    int unsigned addr;
    res.delayed_rgb = px.pixel_rgb;
    res.frame_done  = px.frame_end;
    map_on = (map_width_q != 0) && (map_height_q != 0);
    if (map_on && px.delay_frames != 0 && px.delay_frames <= MAX_DELAY_DEF &&
        px.pixel_x < map_width_q && px.pixel_y < map_height_q) begin
      map_index = px.pixel_y * map_width_q + px.pixel_x;
      // positions past the store capacity pass through
      if (map_index < MAP_PIXELS_DEF) begin
        slot = frame_count_q % px.delay_frames;
        addr = map_index * MAX_DELAY_DEF + slot;
        res.delayed_rgb      = pixel_history[addr];
        pixel_history[addr]  = px.pixel_rgb;
      end
    end
    // an unset map does not count frames
    if (map_on && px.frame_end)
      frame_count_q = frame_count_q + 1;
    return res;
  endfunction

  // both handshakes are sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        due_pixels.push_back(delayed_pixel(in_data_i));
        accepted_count++;
        in_taken = 1'b1;
        tx_wait  = draw_wait(tx_idle_on);
      end
      if (out_valid_o && !out_stall_i) begin
        rx_wait = draw_wait(rx_idle_on);
        if (due_pixels.size() == 0) begin
          $display("%0t: result with no item pending, got rgb %06h done %0b",
                   $time, out_data_o.delayed_rgb, out_data_o.frame_done);
          mismatch_count++;
        end else begin
          pixel_want = due_pixels.pop_front();
          if (out_data_o.delayed_rgb !== pixel_want.delayed_rgb) begin
            $display("%0t: delayed_rgb expected %06h got %06h",
                     $time, pixel_want.delayed_rgb, out_data_o.delayed_rgb);
            mismatch_count++;
          end
          if (out_data_o.frame_done !== pixel_want.frame_done) begin
            $display("%0t: frame_done expected %0b got %0b",
                     $time, pixel_want.frame_done, out_data_o.frame_done);
            mismatch_count++;
          end
        end
      end
    end
  end

  // driver: a stalled item holds, otherwise wait out the gap and offer the next one
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid_i <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        in_data_i  <= pending_pixels.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: long hold on request, else a per-item stall
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      rx_hold       = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic queue_pixel(input int unsigned x, input int unsigned y,
                             input int unsigned rgb, input int unsigned dly,
                             input bit fend);
    pix_in_t px;
    px.pixel_x      = x[X_W-1:0];
    px.pixel_y      = y[Y_W-1:0];
    px.pixel_rgb    = rgb[RGB_W-1:0];
    px.delay_frames = dly[DELAY_W-1:0];
    px.frame_end    = fend;
    pending_pixels.push_back(px);
    queued_count++;
  endtask

  // random position anywhere in the 12-bit range, occasional frame end
  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++)
      queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 24'hFFFFFF),
                  $urandom_range(0, 15), ($urandom_range(0, 5) == 0));
  endtask

  task automatic new_slit_map();
    foreach (slit_delay[i])
      slit_delay[i] = $urandom_range(1, 15);
    slit_delay[$urandom_range(0, 3)] = '0;
  endtask

  // raster-order frames over a small map, last pixel marks frame end
  task automatic queue_frames(input int w, input int h, input int nframes);
    int unsigned dly;
    for (int f = 0; f < nframes; f++)
      for (int yy = 0; yy < h; yy++)
        for (int xx = 0; xx < w; xx++) begin
          dly = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : slit_delay[yy * w + xx];
          queue_pixel(xx, yy, $urandom_range(0, 24'hFFFFFF), dly,
                      (yy == h - 1) && (xx == w - 1));
        end
  endtask

  task automatic write_map_reg(input cfg_reg_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[MAP_W-1:0];
    if (idx == CFG_MAP_WIDTH)
      map_width_q = value[MAP_W-1:0];
    else
      map_height_q = value[MAP_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block idle: every item taken and every result back
  task automatic drain();
    while (pending_pixels.size() != 0 || accepted_count != queued_count ||
           due_pixels.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_map(input int unsigned w, input int unsigned h);
    drain();
    write_map_reg(CFG_MAP_WIDTH, w);
    write_map_reg(CFG_MAP_HEIGHT, h);
  endtask

  // stimulus
  initial begin
    int unsigned hot_x [8];
    int unsigned px_x;
    int unsigned px_y;
    foreach (pixel_history[i])
      pixel_history[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    // the store is swept clear after reset, input stalls meanwhile
    while (in_stall_o) @(negedge clk_i);

    // unset map (zero width): everything passes, frame ends are not counted
    set_map(0, 5);
    queue_pixel(0, 0, 24'hFFFFFF, 1, 1'b1);
    queue_pixel(4095, 4095, 24'h000000, 15, 1'b0);
    queue_pixel(1, 1, 24'h123456, 3, 1'b1);
    queue_noise(20);

    // small map: directed corners, then well-formed frames under a long output hold
    set_map(3, 2);
    queue_pixel(0, 0, 24'hFFFFFF, 1, 1'b0);     // empty history reads zero
    queue_pixel(0, 0, 24'h000000, 1, 1'b1);     // same slot, previous pixel comes back
    queue_pixel(1, 0, 24'hABCDEF, 0, 1'b0);     // zero delay passes through
    queue_pixel(3, 0, 24'h5A5A5A, 2, 1'b0);     // column outside the map
    queue_pixel(0, 2, 24'hA5A5A5, 2, 1'b0);     // row outside the map
    queue_pixel(2, 1, 24'h00FF00, 15, 1'b1);    // deepest delay
    queue_pixel(4095, 4095, 24'hFFFFFF, 15, 1'b0);
    drain();
    new_slit_map();
    tx_idle_on    = 1'b0;
    long_hold_req = 1'b1;   // input side keeps offering while the output is held off
    queue_frames(3, 2, 30);
    drain();
    tx_idle_on = 1'b1;
    queue_noise(20);

    // widest map, one row: full column range with a few hot positions
    set_map(4096, 1);
    queue_pixel(4095, 0, 24'hFFFFFF, 15, 1'b0);
    queue_pixel(0, 0, 24'h000000, 15, 1'b1);
    queue_pixel(0, 1, 24'h777777, 4, 1'b0);
    foreach (hot_x[i])
      hot_x[i] = $urandom_range(0, 4095);
    hot_x[0] = 0;
    hot_x[1] = 4095;
    for (int i = 0; i < 70; i++) begin
      px_x = $urandom_range(0, 1) ? hot_x[$urandom_range(0, 7)] : $urandom_range(0, 4095);
      px_y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : 0;
      queue_pixel(px_x, px_y, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 15),
                  ($urandom_range(0, 3) == 0));
    end

    // tallest map: rows past 63 run beyond the store capacity
    set_map(64, 4096);
    for (int i = 0; i < 40; i++) begin
      px_x = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
      px_y = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
      queue_pixel(px_x, px_y, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 15),
                  ($urandom_range(0, 3) == 0));
    end

    // largest map in both directions
    set_map(4096, 4096);
    queue_pixel(0, 1, 24'h010203, 5, 1'b0);     // first index past capacity
    queue_pixel(4095, 0, 24'hFEDCBA, 5, 1'b1);  // last index inside capacity
    queue_pixel(4095, 4095, 24'h00FFFF, 5, 1'b0);
    queue_noise(15);

    // single-pixel map
    set_map(1, 1);
    new_slit_map();
    queue_frames(1, 1, 20);

    // unset map again, now by zero height; history kept from before
    set_map(5, 0);
    queue_noise(15);

    // small map, no idling on either side
    set_map(2, 2);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    new_slit_map();
    queue_frames(2, 2, 30);
    queue_noise(20);

    drain();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && due_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog on total cycles
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
